/* rtl/core/gds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg
// Shared types and constants for the graph dominator set block.
// ----------------------------------------------------------------------------
package gds_pkg;

   localparam int ROW_WIDTH            = 32;
   localparam int PIVOT_WIDTH          = 5;
   localparam int COUNT_WIDTH          = 6;
   localparam int VERTEX_WIDTH         = 5;
   localparam int MAX_VERTICES_DEFAULT = 32;

   typedef logic [ROW_WIDTH-1:0] row_type;

   // per-cycle command broadcast to every lane
   typedef struct packed {
      logic                   load;
      logic                   warsh;
      logic [PIVOT_WIDTH-1:0] pivot;
   } lane_ctrl_type;

endpackage

/* rtl/core/gds_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_lane
// One graph row: holds its adjacency and closure rows, runs its Warshall
// update and offers its edges to the reachability sweep.
// ----------------------------------------------------------------------------
module gds_lane (
   input  logic                  clock,
   input  gds_pkg::lane_ctrl_type ctrl,
   input  logic                  load_sel,
   input  gds_pkg::row_type      row_data,
   input  gds_pkg::row_type      pivot_row,
   input  logic                  seen_bit,
   output gds_pkg::row_type      closure_row,
   output gds_pkg::row_type      contrib
);

   gds_pkg::row_type adj_ff, adj_in;
   gds_pkg::row_type closure_ff, closure_in;

   // load a row, or fold the pivot row in when this row reaches the pivot
   always_comb begin
      adj_in     = adj_ff;
      closure_in = closure_ff;
      if (ctrl.load && load_sel) begin
         adj_in     = row_data;
         closure_in = row_data;
      end else if (ctrl.warsh && closure_ff[ctrl.pivot]) begin
         closure_in = closure_ff | pivot_row;
      end
   end

   always_ff @(posedge clock) begin
      adj_ff     <= adj_in;
      closure_ff <= closure_in;
   end

   assign closure_row = closure_ff;
   assign contrib     = seen_bit ? adj_ff : '0;

endmodule

/* rtl/core/gds_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_merge
// Combines the edge contributions of all lanes into one frontier word.
// ----------------------------------------------------------------------------
module gds_merge #(
   parameter int ROWS = gds_pkg::MAX_VERTICES_DEFAULT
) (
   input  gds_pkg::row_type contrib [ROWS],
   output gds_pkg::row_type merged
);

   // or across lanes
   always_comb begin
      merged = '0;
      for (int i = 0; i < ROWS; i++) begin
         merged = merged | contrib[i];
      end
   end

endmodule

/* rtl/core/graph_dominator_sets.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dominator_sets
// Dominated-vertex sets of a directed graph loaded as adjacency rows.
// ----------------------------------------------------------------------------
// Usage:
//   csr_write_enable/csr_write_data set the vertex count n (0 acts as 1,
//   values above the row limit saturate); a write restarts row loading.
//   The req channel takes one adjacency row per beat, row 0 first. After
//   row n-1 the block stalls req, runs Warshall (one pivot per cycle across
//   all row lanes), then for each vertex v runs a reachability sweep from
//   vertex 0 with v removed, one frontier step per cycle (skipped for vertex
//   0 and for vertices unreachable from 0), and presents one rsp beat per
//   vertex, vertex 0 first, rsp_last on vertex n-1.
//   While rsp_stall is high the result beat holds and nothing advances.
//   Reset (synchronous) sets n to 32 and empties the row count.
// ----------------------------------------------------------------------------
module graph_dominator_sets #(
   parameter int MAX_VERTICES = gds_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [gds_pkg::COUNT_WIDTH-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gds_pkg::ROW_WIDTH-1:0]       req_adj_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gds_pkg::VERTEX_WIDTH-1:0]    rsp_vertex,
   output logic [gds_pkg::ROW_WIDTH-1:0]       rsp_dominated_mask,
   output logic                                rsp_last
);

   localparam int ROWS = (MAX_VERTICES < gds_pkg::ROW_WIDTH) ? MAX_VERTICES
                                                             : gds_pkg::ROW_WIDTH;
   localparam int IW   = $clog2(ROWS);
   localparam int CW   = gds_pkg::COUNT_WIDTH;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_WARSH = 3'd1;
   localparam logic [2:0] S_PREP  = 3'd2;
   localparam logic [2:0] S_BFS   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    row_ff, row_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    v_ff, v_in;
   gds_pkg::row_type seen_ff, seen_in;
   gds_pkg::row_type mask_ff, mask_in;

   logic [CW-1:0]    n_w;
   logic [CW-1:0]    row_idx;
   gds_pkg::row_type nmask;
   gds_pkg::row_type vbit;
   gds_pkg::row_type allow;
   gds_pkg::row_type merged;
   gds_pkg::row_type next_seen;
   gds_pkg::row_type sel_row;
   logic [IW-1:0]    rd_idx;
   logic             accept;

   gds_pkg::lane_ctrl_type ctrl;
   gds_pkg::row_type       closure_rows [ROWS];
   gds_pkg::row_type       contribs     [ROWS];

   // active vertex count and masks
   always_comb begin
      if (count_ff == '0)               n_w = CW'(1);
      else if (count_ff > CW'(ROWS))    n_w = CW'(ROWS);
      else                              n_w = count_ff;
   end
   assign nmask   = gds_pkg::ROW_WIDTH'((33'd1 << n_w) - 33'd1);
   assign vbit    = gds_pkg::ROW_WIDTH'(1) << v_ff[gds_pkg::PIVOT_WIDTH-1:0];
   assign allow   = nmask & ~vbit;
   assign row_idx = (row_ff >= n_w) ? '0 : row_ff;
   assign accept  = req_valid && !req_stall;

   // lane commands
   always_comb begin
      ctrl.load  = accept;
      ctrl.warsh = (state_ff == S_WARSH);
      ctrl.pivot = k_ff[gds_pkg::PIVOT_WIDTH-1:0];
   end

   // one shared row read: pivot during Warshall, vertex afterwards
   assign rd_idx  = (state_ff == S_WARSH) ? k_ff[IW-1:0] : v_ff[IW-1:0];
   assign sel_row = closure_rows[rd_idx];

   // row lanes
   for (genvar g = 0; g < ROWS; g++) begin : g_lane
      gds_lane u_lane (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_sel   (row_idx[IW-1:0] == IW'(g)),
         .row_data   (req_adj_row & nmask),
         .pivot_row  (sel_row),
         .seen_bit   (seen_ff[g]),
         .closure_row(closure_rows[g]),
         .contrib    (contribs[g])
      );
   end

   gds_merge #(.ROWS(ROWS)) u_merge (
      .contrib(contribs),
      .merged (merged)
   );

   assign next_seen = seen_ff | (merged & allow);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      v_in     = v_ff;
      seen_in  = seen_ff;
      mask_in  = mask_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (row_idx + CW'(1) >= n_w) begin
                  row_in   = '0;
                  k_in     = '0;
                  state_in = S_WARSH;
               end else begin
                  row_in = row_idx + CW'(1);
               end
            end
         end
         S_WARSH: begin
            k_in = k_ff + CW'(1);
            if (k_ff == n_w - CW'(1)) begin
               v_in     = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (v_ff == '0) begin
               mask_in  = (closure_rows[0] | vbit) & nmask;
               state_in = S_OUT;
            end else if (closure_rows[0][v_ff[gds_pkg::PIVOT_WIDTH-1:0]]) begin
               seen_in  = gds_pkg::ROW_WIDTH'(1);
               state_in = S_BFS;
            end else begin
               mask_in  = '0;
               state_in = S_OUT;
            end
         end
         S_BFS: begin
            seen_in = next_seen;
            if (next_seen == seen_ff) begin
               mask_in  = ((sel_row & ~seen_ff) | vbit) & nmask;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               seen_in = '0;
               if (v_ff == n_w - CW'(1)) begin
                  state_in = S_LOAD;
               end else begin
                  v_in     = v_ff + CW'(1);
                  state_in = S_PREP;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
      if (csr_write_enable) begin
         count_in = csr_write_data;
         row_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= CW'(32);
         row_ff   <= '0;
         k_ff     <= '0;
         v_ff     <= '0;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         row_ff   <= row_in;
         k_ff     <= k_in;
         v_ff     <= v_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end

   // ports
   assign req_stall          = (state_ff != S_LOAD);
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_vertex         = v_ff[gds_pkg::VERTEX_WIDTH-1:0];
   assign rsp_dominated_mask = mask_ff;
   assign rsp_last           = (v_ff == n_w - CW'(1));

endmodule

/* rtl/core/gds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_checker
// Port-level checks for graph_dominator_sets, bound to the top level.
// ----------------------------------------------------------------------------
module gds_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [gds_pkg::VERTEX_WIDTH-1:0]    rsp_vertex,
   input logic [gds_pkg::ROW_WIDTH-1:0]       rsp_dominated_mask,
   input logic                                rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex)
                                 && $stable(rsp_dominated_mask))
      else $error("stalled result beat changed");

   // no rows are taken while results are pending
   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during result phase");

   // vertex 0 always dominates itself
   a_origin_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vertex == '0 |-> rsp_dominated_mask[0])
      else $error("origin missing from its own set");

   // after the last beat the block returns to loading
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid && !req_stall)
      else $error("block did not reopen after last result");

endmodule

bind graph_dominator_sets gds_checker u_gds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_vertex        (rsp_vertex),
   .rsp_dominated_mask(rsp_dominated_mask),
   .rsp_last          (rsp_last)
);
